FILE: rtl/bgcm_pkg.sv
// ----------------------------------------------------------------------------
// Bounded greedy change maker package
// Widths shared by the channel interfaces and the datapath.
// ----------------------------------------------------------------------------
package bgcm_pkg;

    // Width of the amount still to pay.
    localparam int AMOUNT_BITS = 24;
    // Width of a note count.
    localparam int COUNT_BITS  = 16;
    // Width of a face value.
    localparam int VALUE_BITS  = 16;
    // Width of the product of a count and a face value.
    localparam int PROD_BITS   = COUNT_BITS + VALUE_BITS;
    // Width of the step counter of the divider.
    localparam int STEP_BITS   = $clog2(AMOUNT_BITS + 1);

    typedef logic [AMOUNT_BITS-1:0] amount_t;
    typedef logic [COUNT_BITS-1:0]  count_t;
    typedef logic [VALUE_BITS-1:0]  value_t;
    typedef logic [PROD_BITS-1:0]   prod_t;
    typedef logic [STEP_BITS-1:0]   step_t;

endpackage

FILE: rtl/bgcm_if.sv
// ----------------------------------------------------------------------------
// Bounded greedy change maker channels
// Valid/ready channels for denomination items and for result items.
// ----------------------------------------------------------------------------
interface bgcm_in_if;

    logic               valid;
    logic               ready;
    bgcm_pkg::value_t   denom_value;
    bgcm_pkg::count_t   denom_stock;
    logic               first_denom;
    bgcm_pkg::amount_t  amount_request;
    logic               last_denom;

    modport source
    (
        output valid,
        output denom_value,
        output denom_stock,
        output first_denom,
        output amount_request,
        output last_denom,
        input  ready
    );

    modport sink
    (
        input  valid,
        input  denom_value,
        input  denom_stock,
        input  first_denom,
        input  amount_request,
        input  last_denom,
        output ready
    );

endinterface

interface bgcm_out_if;

    logic              valid;
    logic              ready;
    bgcm_pkg::count_t  notes_given;
    logic              request_done;
    logic              paid_in_full;

    modport source
    (
        output valid,
        output notes_given,
        output request_done,
        output paid_in_full,
        input  ready
    );

    modport sink
    (
        input  valid,
        input  notes_given,
        input  request_done,
        input  paid_in_full,
        output ready
    );

endinterface

FILE: rtl/bounded_greedy_change_maker.sv
// ----------------------------------------------------------------------------
// Bounded greedy change maker
// Pays out an amount denomination by denomination with a limited stock of
// notes, using one shared restoring divider and one multiplier.
// ----------------------------------------------------------------------------
//
//  channel | dir | carries
//  --------+-----+-----------------------------------------------------------
//  din     | in  | face value, stock, first/last marks, amount to pay
//  dout    | out | notes to dispense, request done, paid in full
//
// A denomination with a nonzero face value takes S_DIV for the 24 divider
// steps, one quotient bit per cycle, then S_PICK, and S_MUL and S_SUB
// (multiply and subtract) when the stock does not cover the quotient, then
// S_FINISH to hand over the result. A zero face value goes straight to
// S_FINISH. Reset clears the remaining amount.
// The result waits in an output register; a stall on dout holds only the
// hand-over of the following result.
//
module bounded_greedy_change_maker
(
    input  logic            clk,
    input  logic            rst_n,
    bgcm_in_if.sink         din,
    bgcm_out_if.source      dout
);

    typedef enum logic [2:0]
    {
        S_IDLE,
        S_DIV,
        S_PICK,
        S_MUL,
        S_SUB,
        S_FINISH
    } state_t;

    state_t             state_reg, state_next;
    bgcm_pkg::amount_t  remaining_reg, remaining_next;
    bgcm_pkg::amount_t  quot_reg, quot_next;
    bgcm_pkg::value_t   part_reg, part_next;
    bgcm_pkg::value_t   value_reg, value_next;
    bgcm_pkg::count_t   stock_reg, stock_next;
    bgcm_pkg::count_t   notes_reg, notes_next;
    bgcm_pkg::prod_t    prod_reg, prod_next;
    bgcm_pkg::step_t    step_reg, step_next;
    logic               last_reg, last_next;

    logic               out_valid_reg, out_valid_next;
    bgcm_pkg::count_t   out_notes_reg, out_notes_next;
    logic               out_done_reg, out_done_next;
    logic               out_paid_reg, out_paid_next;

    logic [bgcm_pkg::VALUE_BITS:0] shifted;
    logic                          fits;
    logic                          accept;
    logic                          out_free;

    assign accept   = din.valid && din.ready;
    assign out_free = !out_valid_reg || dout.ready;

    assign din.ready         = (state_reg == S_IDLE);
    assign dout.valid        = out_valid_reg;
    assign dout.notes_given  = out_notes_reg;
    assign dout.request_done = out_done_reg;
    assign dout.paid_in_full = out_paid_reg;

    // One restoring division step: bring down the next dividend bit.
    assign shifted = {part_reg, quot_reg[bgcm_pkg::AMOUNT_BITS-1]};
    assign fits    = (shifted >= {1'b0, value_reg});

    always_comb
    begin
        state_next     = state_reg;
        remaining_next = remaining_reg;
        quot_next      = quot_reg;
        part_next      = part_reg;
        value_next     = value_reg;
        stock_next     = stock_reg;
        notes_next     = notes_reg;
        prod_next      = prod_reg;
        step_next      = step_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg && !dout.ready;
        out_notes_next = out_notes_reg;
        out_done_next  = out_done_reg;
        out_paid_next  = out_paid_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    value_next = din.denom_value;
                    stock_next = din.denom_stock;
                    last_next  = din.last_denom;
                    notes_next = '0;
                    part_next  = '0;
                    step_next  = '0;
                    if (din.first_denom)
                    begin
                        remaining_next = din.amount_request;
                        quot_next      = din.amount_request;
                    end
                    else
                    begin
                        quot_next = remaining_reg;
                    end
                    if (din.denom_value == '0)
                    begin
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        state_next = S_DIV;
                    end
                end
            end

            S_DIV:
            begin
                if (fits)
                begin
                    part_next = bgcm_pkg::VALUE_BITS'(shifted - {1'b0, value_reg});
                end
                else
                begin
                    part_next = shifted[bgcm_pkg::VALUE_BITS-1:0];
                end
                quot_next = {quot_reg[bgcm_pkg::AMOUNT_BITS-2:0], fits};
                step_next = step_reg + 1'b1;
                if (step_reg == bgcm_pkg::STEP_BITS'(bgcm_pkg::AMOUNT_BITS - 1))
                begin
                    state_next = S_PICK;
                end
            end

            S_PICK:
            begin
                // When the stock covers the quotient, the remainder is the new amount.
                if (quot_reg <= bgcm_pkg::AMOUNT_BITS'(stock_reg))
                begin
                    notes_next     = bgcm_pkg::COUNT_BITS'(quot_reg);
                    remaining_next = bgcm_pkg::AMOUNT_BITS'(part_reg);
                    state_next     = S_FINISH;
                end
                else
                begin
                    notes_next = stock_reg;
                    state_next = S_MUL;
                end
            end

            S_MUL:
            begin
                prod_next  = bgcm_pkg::PROD_BITS'(stock_reg) * bgcm_pkg::PROD_BITS'(value_reg);
                state_next = S_SUB;
            end

            S_SUB:
            begin
                // The stock is short of the quotient here, so the product fits.
                remaining_next = remaining_reg - bgcm_pkg::AMOUNT_BITS'(prod_reg);
                state_next     = S_FINISH;
            end

            S_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_notes_next = notes_reg;
                    out_done_next  = last_reg;
                    out_paid_next  = last_reg && (remaining_reg == '0);
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            remaining_reg <= '0;
            quot_reg      <= '0;
            part_reg      <= '0;
            value_reg     <= '0;
            stock_reg     <= '0;
            notes_reg     <= '0;
            prod_reg      <= '0;
            step_reg      <= '0;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            out_notes_reg <= '0;
            out_done_reg  <= 1'b0;
            out_paid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            remaining_reg <= remaining_next;
            quot_reg      <= quot_next;
            part_reg      <= part_next;
            value_reg     <= value_next;
            stock_reg     <= stock_next;
            notes_reg     <= notes_next;
            prod_reg      <= prod_next;
            step_reg      <= step_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
            out_notes_reg <= out_notes_next;
            out_done_reg  <= out_done_next;
            out_paid_reg  <= out_paid_next;
        end
    end

    // The partial remainder always stays below the divisor.
    a_part_below_value: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (part_reg < value_reg))
        else $error("partial remainder reached the divisor");

    // The worth of a short stock never exceeds the amount still to pay.
    a_prod_fits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SUB) |-> (prod_reg <= bgcm_pkg::PROD_BITS'(remaining_reg)))
        else $error("dispensed worth exceeds remaining amount");

    // Paid in full is only ever reported on the last result of a request.
    a_paid_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        (dout.valid && dout.paid_in_full) |-> dout.request_done)
        else $error("paid in full flagged on a result that is not the last");

    // The FSM stays in S_FINISH while the output register is still full.
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FINISH && !out_free) |=> (state_reg == S_FINISH))
        else $error("result lost while the output register was full");

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded greedy change maker testbench
// Drives denomination items through the input channel and compares every
// result transfer with a typed expectation from the table of corner cases or
// a cycle-free model of the greedy payout. The table comes first, followed by
// randomized requests and noise, with bursty sending and a stalling receiver.
// ----------------------------------------------------------------------------
module testbench;

    localparam int RANDOM_ITEMS = 850;
    localparam int STALL_LIMIT  = 3000;
    localparam int DRAIN_CYCLES = 60;
    localparam int ROW_COUNT    = 14;

    typedef struct packed
    {
        bgcm_pkg::value_t   value;
        bgcm_pkg::count_t   stock;
        logic               first;
        bgcm_pkg::amount_t  amount;
        logic               last;
        logic               typed;
        bgcm_pkg::count_t   typed_notes;
        logic               typed_done;
        logic               typed_paid;
    } denom_item_t;

    typedef struct packed
    {
        bgcm_pkg::count_t  notes;
        logic              done;
        logic              paid;
    } payout_t;

    logic clk;
    logic rst_n;

    bgcm_in_if  din_if ();
    bgcm_out_if dout_if ();

    bounded_greedy_change_maker u_dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .din   (din_if),
        .dout  (dout_if)
    );

    bgcm_pkg::amount_t  remaining_amt;
    payout_t            payout_expected [$];
    denom_item_t        feed [$];
    int unsigned        error_count;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch: %s", msg);
        error_count++;
    endtask

    // Greedy step: as many notes as fit, capped by the stock on hand.
    function automatic payout_t predict_payout(input denom_item_t d);
        payout_t            res;
        bgcm_pkg::amount_t  quot;
        bgcm_pkg::prod_t    worth;
        res.notes = '0;
        if (d.first)
            remaining_amt = d.amount;
        if (d.value != '0)
        begin
            quot = remaining_amt / bgcm_pkg::amount_t'(d.value);
            res.notes = (quot < bgcm_pkg::amount_t'(d.stock)) ?
                bgcm_pkg::count_t'(quot) : d.stock;
            worth = bgcm_pkg::prod_t'(res.notes) * bgcm_pkg::prod_t'(d.value);
            remaining_amt = remaining_amt - bgcm_pkg::amount_t'(worth);
        end
        res.done = d.last;
        res.paid = d.last && (remaining_amt == '0);
        return res;
    endfunction

    // Result checking against the oldest outstanding expectation.
    always @(posedge clk)
    begin : result_check
        payout_t want;
        if (rst_n && dout_if.valid && dout_if.ready)
        begin
            if (payout_expected.size() == 0)
                report_mismatch($sformatf("unexpected result notes=%0d done=%0b paid=%0b",
                    dout_if.notes_given, dout_if.request_done, dout_if.paid_in_full));
            else
            begin
                want = payout_expected.pop_front();
                if (dout_if.notes_given !== want.notes)
                    report_mismatch($sformatf("notes_given %0d, expected %0d",
                        dout_if.notes_given, want.notes));
                if (dout_if.request_done !== want.done)
                    report_mismatch($sformatf("request_done %0b, expected %0b",
                        dout_if.request_done, want.done));
                if (dout_if.paid_in_full !== want.paid)
                    report_mismatch($sformatf("paid_in_full %0b, expected %0b",
                        dout_if.paid_in_full, want.paid));
            end
        end
    end

    // Receiver: segments of always-ready, coin-flip and periodic stalls.
    initial
    begin : receiver
        int seg_left;
        int mode;
        int period;
        int phase;
        seg_left = 0;
        mode = 0;
        period = 1;
        phase = 0;
        dout_if.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (seg_left == 0)
            begin
                seg_left = $urandom_range(20, 300);
                mode = $urandom_range(0, 2);
                period = $urandom_range(2, 40);
                phase = 0;
            end
            seg_left--;
            phase++;
            case (mode)
                0:       dout_if.ready <= 1'b1;
                1:       dout_if.ready <= 1'($urandom_range(0, 1));
                default: dout_if.ready <= ((phase % period) == 0);
            endcase
        end
    end

    initial
    begin : watchdog
        int unsigned idle;
        idle = 0;
        while (idle < STALL_LIMIT)
        begin
            @(posedge clk);
            if (rst_n && ((din_if.valid && din_if.ready) || (dout_if.valid && dout_if.ready)))
                idle = 0;
            else
                idle++;
        end
        $display("testbench: errors");
        $finish;
    end

    initial
    begin : stimulus
        denom_item_t rows [ROW_COUNT];
        denom_item_t it;
        payout_t     predicted;
        int          ndenom;
        int          top;
        int          burst_left;
        int          gap;
        bit          broken;

        error_count = 0;
        remaining_amt = '0;
        rst_n = 1'b0;
        din_if.valid = 1'b0;
        din_if.denom_value = '0;
        din_if.denom_stock = '0;
        din_if.first_denom = 1'b0;
        din_if.amount_request = '0;
        din_if.last_denom = 1'b0;

        // value, stock, first, amount, last, typed, notes, done, paid
        rows = '{
            // Continuation right after reset: nothing left to pay.
            '{16'd5,     16'd10,    1'b0, 24'hFFFFFF, 1'b1, 1'b1, 16'd0,     1'b1, 1'b1},
            // Zero amount pays nothing and completes in full.
            '{16'd100,   16'hFFFF,  1'b1, 24'd0,      1'b0, 1'b1, 16'd0,     1'b0, 1'b0},
            '{16'd1,     16'd5,     1'b0, 24'h123456, 1'b1, 1'b1, 16'd0,     1'b1, 1'b1},
            // Largest amount, unit face value, full stock.
            '{16'd1,     16'hFFFF,  1'b1, 24'hFFFFFF, 1'b0, 1'b1, 16'hFFFF,  1'b0, 1'b0},
            '{16'hFFFF,  16'hFFFF,  1'b0, 24'd0,      1'b0, 1'b0, 16'd0,     1'b0, 1'b0},
            '{16'd1,     16'd0,     1'b0, 24'd0,      1'b1, 1'b1, 16'd0,     1'b1, 1'b0},
            // A new item without a first mark carries over the leftover.
            '{16'd255,   16'd1,     1'b0, 24'hABCDEF, 1'b1, 1'b1, 16'd1,     1'b1, 1'b1},
            // Zero face value keeps the amount.
            '{16'd0,     16'd100,   1'b1, 24'd1000,   1'b0, 1'b1, 16'd0,     1'b0, 1'b0},
            '{16'd100,   16'd3,     1'b0, 24'd0,      1'b0, 1'b0, 16'd0,     1'b0, 1'b0},
            '{16'd50,    16'hFFFF,  1'b0, 24'd0,      1'b0, 1'b0, 16'd0,     1'b0, 1'b0},
            '{16'd10,    16'd5,     1'b0, 24'd0,      1'b1, 1'b1, 16'd0,     1'b1, 1'b1},
            '{16'd7,     16'd1,     1'b1, 24'd7,      1'b1, 1'b1, 16'd1,     1'b1, 1'b1},
            '{16'hFFFF,  16'd0,     1'b1, 24'hFFFFFF, 1'b1, 1'b1, 16'd0,     1'b1, 1'b0},
            '{16'd256,   16'hFFFF,  1'b1, 24'hFFFFFF, 1'b1, 1'b0, 16'd0,     1'b0, 1'b0}
        };
        foreach (rows[i])
            feed.push_back(rows[i]);

        while (feed.size() < ROW_COUNT + RANDOM_ITEMS)
        begin
            it = '0;
            if ($urandom_range(0, 99) < 15)
            begin
                // Noise: arbitrary marks, order and values.
                it.value = ($urandom_range(0, 7) == 0) ?
                    bgcm_pkg::value_t'(0) : bgcm_pkg::value_t'($urandom);
                it.stock = bgcm_pkg::count_t'($urandom);
                it.first = 1'($urandom);
                it.amount = bgcm_pkg::amount_t'($urandom);
                it.last = 1'($urandom);
                feed.push_back(it);
            end
            else
            begin
                ndenom = $urandom_range(1, 6);
                broken = ($urandom_range(0, 9) == 0);
                top = $urandom_range(0, 1) ? $urandom_range(1, 65535) : $urandom_range(1, 1000);
                for (int k = 0; k < ndenom; k++)
                begin
                    it.value = bgcm_pkg::value_t'(top);
                    if (k == ndenom - 1 && $urandom_range(0, 2) == 0)
                        it.value = bgcm_pkg::value_t'(1);
                    if (broken && $urandom_range(0, 3) == 0)
                        it.value = '0;
                    case ($urandom_range(0, 3))
                        0:       it.stock = bgcm_pkg::count_t'($urandom_range(0, 3));
                        1:       it.stock = bgcm_pkg::count_t'($urandom_range(0, 100));
                        2:       it.stock = '1;
                        default: it.stock = bgcm_pkg::count_t'($urandom);
                    endcase
                    it.first = (k == 0);
                    if (k == 0)
                        it.amount = bgcm_pkg::amount_t'($urandom >> $urandom_range(8, 32));
                    else
                        it.amount = bgcm_pkg::amount_t'($urandom);
                    it.last = (k == ndenom - 1) && !(broken && $urandom_range(0, 1) == 1);
                    feed.push_back(it);
                    top = $urandom_range(1, top);
                end
            end
        end

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        burst_left = 0;
        while (feed.size() != 0)
        begin
            if (burst_left == 0)
            begin
                gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(0, 30);
                if (gap > 0)
                begin
                    din_if.valid <= 1'b0;
                    din_if.denom_value <= bgcm_pkg::value_t'($urandom);
                    din_if.denom_stock <= bgcm_pkg::count_t'($urandom);
                    din_if.first_denom <= 1'($urandom);
                    din_if.amount_request <= bgcm_pkg::amount_t'($urandom);
                    din_if.last_denom <= 1'($urandom);
                    repeat (gap) @(negedge clk);
                end
                burst_left = ($urandom_range(0, 9) == 0) ? 100 : $urandom_range(1, 12);
            end
            it = feed.pop_front();
            din_if.valid <= 1'b1;
            din_if.denom_value <= it.value;
            din_if.denom_stock <= it.stock;
            din_if.first_denom <= it.first;
            din_if.amount_request <= it.amount;
            din_if.last_denom <= it.last;
            @(posedge clk);
            while (!din_if.ready)
                @(posedge clk);
            // The transfer happened at this edge; the model advances with it.
            predicted = predict_payout(it);
            if (it.typed)
                payout_expected.push_back(payout_t'{it.typed_notes, it.typed_done, it.typed_paid});
            else
                payout_expected.push_back(predicted);
            burst_left--;
            @(negedge clk);
        end
        din_if.valid <= 1'b0;

        while (payout_expected.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
